### rtl/core/gcbs_pkg.sv
// Shared types and constants for the glyph code binary search block.
// Used by gcbs_ctrl, gcbs_datapath, glyph_code_binary_search, glyph_lookup_checker and tb; no dependencies.
`default_nettype none

package gcbs_pkg;

	// Fixed field widths
	localparam int unsigned CODE_W  = 21;
	localparam int unsigned INDEX_W = 10;
	localparam int unsigned COUNT_W = 11;

	// Item commands
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// Register map (word index)
	localparam logic REG_ENTRY_COUNT = 1'b0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_HOLD
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic wr_en;     // store one table entry
		logic start;     // latch code and open the full search range
		logic rd;        // read the midpoint entry
		logic cmp;       // registered entry is valid for compare
		logic step;      // narrow the range around the midpoint
		logic out_load;  // move the midpoint into the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic count_zero;  // table holds no entries
		logic hit;         // probed entry equals the searched code
		logic range_end;   // no entries left after this probe
		logic out_free;    // output register can take a result this cycle
	} sts_t;

endpackage

`default_nettype wire

### rtl/core/glyph_code_binary_search.sv
// Glyph code binary search: a sorted table of character codes with a lookup
// that returns the index of the matching entry. A write item is stored when
// it is accepted and leaves the controller idle. A lookup into a non-empty
// table starts on accept and then probes one midpoint at a time, each probe a
// read state and then a compare state, since the single table memory has a
// registered read that feeds the compare before the next midpoint is known.
// A hit that meets a full output register holds the controller until the
// result can be loaded. A lookup that finds no match returns nothing. A new
// item is taken while a result still waits in the output register.
// Top level; depends on gcbs_pkg, gcbs_ctrl and gcbs_datapath.
`default_nettype none

module glyph_code_binary_search #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// request channel
	input  wire                           req_valid,
	output logic                          req_ready,
	input  wire                           command,
	input  wire [gcbs_pkg::INDEX_W-1:0]   entry_index,
	input  wire [gcbs_pkg::CODE_W-1:0]    char_code,
	// response channel
	output logic                          rsp_valid,
	input  wire                           rsp_ready,
	output logic [gcbs_pkg::INDEX_W-1:0]  glyph_index,
	// register port
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire [2:0]                     paddr,
	input  wire [31:0]                    pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import gcbs_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic               reg_wr;
	cmd_t               cmd;
	sts_t               sts;

	// Register write on the access phase
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (reg_wr) begin
			count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// Register read
	assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? 32'(count_q) : '0;

	gcbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.command   (command),
		.sts       (sts),
		.cmd       (cmd)
	);

	gcbs_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.entry_count (count_q),
		.entry_index (entry_index),
		.char_code   (char_code),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.glyph_index (glyph_index)
	);

endmodule

`default_nettype wire

### rtl/core/gcbs_ctrl.sv
// Search controller: sequences one table probe (read, compare) at a time.
// Depends on gcbs_pkg.
`default_nettype none

module gcbs_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  wire              command,
	input  gcbs_pkg::sts_t   sts,
	output gcbs_pkg::cmd_t   cmd
);
	import gcbs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = req_valid && req_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && command == CMD_LOOKUP && !sts.count_zero) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.hit) begin
					state_d = sts.out_free ? S_IDLE : S_HOLD;
				end else if (sts.range_end) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_READ;
				end
			end
			S_HOLD: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		req_ready    = (state_q == S_IDLE);
		cmd          = '0;
		cmd.wr_en    = accept && command == CMD_WRITE;
		cmd.start    = accept && command == CMD_LOOKUP && !sts.count_zero;
		cmd.rd       = (state_q == S_READ);
		cmd.cmp      = (state_q == S_CMP);
		cmd.step     = (state_q == S_CMP) && !sts.hit;
		cmd.out_load = ((state_q == S_CMP && sts.hit) || state_q == S_HOLD) && sts.out_free;
	end

	// Checks
	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded into a full output register");

	a_hold_from_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD && !$past(state_q == S_HOLD)) |-> $past(sts.hit && cmd.cmp))
		else $error("hold entered without a hit");

	a_read_then_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> cmd.cmp)
		else $error("probe read not followed by compare");

endmodule

`default_nettype wire

### rtl/core/gcbs_datapath.sv
// Search datapath: code table memory, search bounds, compare and result register.
// Depends on gcbs_pkg.
`default_nettype none

module gcbs_datapath #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  gcbs_pkg::cmd_t                     cmd,
	output gcbs_pkg::sts_t                     sts,
	input  wire [gcbs_pkg::COUNT_W-1:0]        entry_count,
	input  wire [gcbs_pkg::INDEX_W-1:0]        entry_index,
	input  wire [gcbs_pkg::CODE_W-1:0]         char_code,
	output logic                               rsp_valid,
	input  wire                                rsp_ready,
	output logic [gcbs_pkg::INDEX_W-1:0]       glyph_index
);
	import gcbs_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic [CODE_W-1:0]  mem [TABLE_DEPTH];
	logic [CODE_W-1:0]  rd_q;
	logic [CODE_W-1:0]  code_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hi_q;
	logic [AW-1:0]      mid_q;
	logic [CW:0]        sum;
	logic [AW-1:0]      mid_w;
	logic [CW-1:0]      mid_ext;
	logic [CW-1:0]      n_sat;
	logic               wr_ok;
	logic               gt;
	logic               out_valid_q;
	logic [INDEX_W-1:0] glyph_q;

	// Entry count limited to the table depth
	assign n_sat = (32'(entry_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entry_count);
	assign wr_ok = (32'(entry_index) < TABLE_DEPTH);

	// Midpoint of the current range
	assign sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w   = AW'(sum >> 1);
	assign mid_ext = CW'(mid_q);

	// Table write port
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem[AW'(entry_index)] <= char_code;
		end
	end

	// Table read port, registered
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q  <= mem[mid_w];
			mid_q <= mid_w;
		end
	end

	// Search bounds
	assign gt = (rd_q > code_q);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			code_q <= char_code;
			lo_q   <= '0;
			hi_q   <= n_sat - CW'(1);
		end else if (cmd.step) begin
			if (gt) begin
				hi_q <= mid_ext - CW'(1);
			end else begin
				lo_q <= mid_ext + CW'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			glyph_q <= INDEX_W'(mid_q);
		end
	end

	assign rsp_valid   = out_valid_q;
	assign glyph_index = glyph_q;

	// Status
	always_comb begin
		sts            = '0;
		sts.count_zero = (entry_count == '0);
		sts.hit        = (rd_q == code_q);
		sts.range_end  = gt ? (mid_ext == lo_q) : (mid_ext == hi_q);
		sts.out_free   = !out_valid_q || rsp_ready;
	end

	// Checks
	a_range_open: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (lo_q <= hi_q))
		else $error("probe issued on an empty range");

	a_mid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp |-> (mid_ext >= lo_q && mid_ext <= hi_q))
		else $error("midpoint outside search range");

	a_hi_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (32'(hi_q) < TABLE_DEPTH))
		else $error("search range beyond table depth");

endmodule

`default_nettype wire

### verif/glyph_lookup_checker.sv
// Result checker for glyph_code_binary_search: watches the request, response and
// register ports, keeps its own code table and predicts each lookup result.
// Depends on gcbs_pkg for field widths, commands and the register index.
`default_nettype none

module glyph_lookup_checker #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           req_valid,
	input  wire                           req_ready,
	input  wire                           command,
	input  wire [gcbs_pkg::INDEX_W-1:0]   entry_index,
	input  wire [gcbs_pkg::CODE_W-1:0]    char_code,
	input  wire                           rsp_valid,
	input  wire                           rsp_ready,
	input  wire [gcbs_pkg::INDEX_W-1:0]   glyph_index,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire                           pready,
	input  wire [2:0]                     paddr,
	input  wire [31:0]                    pwdata,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import gcbs_pkg::*;

	localparam logic [2:0] COUNT_ADDR = 3'(REG_ENTRY_COUNT) << 2;
	localparam int REPORT_LIMIT = 10;

	// Shadow of the block state
	bit [CODE_W-1:0]  codes [TABLE_DEPTH];
	bit [COUNT_W-1:0] table_size;

	// Glyph indexes still owed by the block, oldest first
	bit [INDEX_W-1:0] expected_glyphs [$];
	bit [INDEX_W-1:0] want_index, hit_index;
	int mismatches = 0;

	// Binary search over the first table_size entries (saturated to the depth)
	function automatic bit search_table(input bit [CODE_W-1:0] code,
			output bit [INDEX_W-1:0] found_at);
		int unsigned span, left, right, mid;
		found_at = '0;
		span = (table_size > TABLE_DEPTH) ? TABLE_DEPTH : table_size;
		if (span == 0)
			return 1'b0;
		left = 0;
		right = span - 1;
		while (left <= right) begin
			mid = (left + right) / 2;
			if (codes[mid] == code) begin
				found_at = INDEX_W'(mid);
				return 1'b1;
			end
			if (codes[mid] > code) begin
				// left edge: nothing smaller remains
				if (mid == 0)
					return 1'b0;
				right = mid - 1;
			end else begin
				left = mid + 1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void note_mismatch(input string what, input int want, input int got);
		if (mismatches < REPORT_LIMIT)
			$display("%0t: %s: expected glyph_index %0d, got %0d", $realtime, what, want, got);
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size = '0;
			expected_glyphs.delete();
			pending <= 0;
			fail_count <= mismatches;
		end else begin
			// register write
			if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
				table_size = pwdata[COUNT_W-1:0];

			// result transfer against the oldest expectation
			if (rsp_valid && rsp_ready) begin
				if (expected_glyphs.size() == 0) begin
					note_mismatch("result with nothing pending", -1, int'(glyph_index));
				end else begin
					want_index = expected_glyphs.pop_front();
					if (glyph_index !== want_index)
						note_mismatch("wrong result", int'(want_index), int'(glyph_index));
				end
			end

			// request transfer: store or predict
			if (req_valid && req_ready) begin
				if (command == CMD_WRITE) begin
					if (entry_index < TABLE_DEPTH)
						codes[entry_index] = char_code;
				end else if (search_table(char_code, hit_index)) begin
					expected_glyphs.push_back(hit_index);
				end
			end

			pending <= expected_glyphs.size();
			fail_count <= mismatches;
		end
	end

endmodule

`default_nettype wire

### verif/tb.sv
// Testbench top for glyph_code_binary_search: clock, reset, table fills, lookups,
// register writes, random idling on both channels and the final verdict.
// Depends on gcbs_pkg, glyph_code_binary_search and glyph_lookup_checker.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gcbs_pkg::*;

	localparam int unsigned DEPTH = 1024;
	localparam int unsigned CODE_MAX = 1114111;
	localparam int unsigned INDEX_MAX = DEPTH - 1;
	localparam logic [2:0] COUNT_ADDR = 3'(REG_ENTRY_COUNT) << 2;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT = 5000;

	typedef enum {FILL_KEEP, FILL_ASCENDING, FILL_REPEATS, FILL_SCRAMBLED} fill_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	logic command;
	logic [INDEX_W-1:0] entry_index;
	logic [CODE_W-1:0] char_code;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [INDEX_W-1:0] glyph_index;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	int fail_count, pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_cycles = 0;

	// Stimulus-side copy of the table, used to pick codes that hit
	bit [CODE_W-1:0] shadow_codes [DEPTH];
	bit shadow_written [DEPTH];

	glyph_code_binary_search #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.command(command), .entry_index(entry_index), .char_code(char_code),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .glyph_index(glyph_index),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	glyph_lookup_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.command(command), .entry_index(entry_index), .char_code(char_code),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .glyph_index(glyph_index),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: random backpressure on the result channel
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// One request transfer; valid is left high for a back-to-back item
	task automatic send_item(input logic cmd, input int unsigned idx, input int unsigned code);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		command <= cmd;
		entry_index <= INDEX_W'(idx);
		char_code <= CODE_W'(code);
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic store_code(input int unsigned idx, input int unsigned code);
		shadow_codes[idx] = CODE_W'(code);
		shadow_written[idx] = 1'b1;
		send_item(CMD_WRITE, idx, code);
	endtask

	// Lookup; entry_index carries random bits since the block ignores it
	task automatic find_code(input int unsigned code);
		send_item(CMD_LOOKUP, $urandom_range(0, INDEX_MAX), code);
	endtask

	// Let outstanding lookups finish before the register changes
	task automatic wait_quiet();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_entry_count(input int unsigned count);
		wait_quiet();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COUNT_ADDR;
		pwdata <= count;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_op(input int unsigned span);
		int unsigned pick, code;
		pick = $urandom_range(0, 99);
		if (pick < 55 && span > 0) begin
			find_code(shadow_codes[$urandom_range(0, span - 1)]);
		end else if (pick < 70) begin
			find_code($urandom_range(0, CODE_MAX));
		end else if (pick < 78 && span > 0) begin
			// just beside a stored code
			code = shadow_codes[$urandom_range(0, span - 1)];
			if ($urandom_range(0, 1))
				code = (code < CODE_MAX) ? code + 1 : code;
			else
				code = (code > 0) ? code - 1 : code;
			find_code(code);
		end else if (pick < 84) begin
			find_code($urandom_range(0, 1) ? CODE_MAX : 0);
		end else begin
			store_code($urandom_range(0, INDEX_MAX), $urandom_range(0, CODE_MAX));
		end
	endtask

	// Set the count, lay out the searched range, then a random op stream
	task automatic run_phase(input int unsigned count, input int ops, input fill_t fill);
		int unsigned span, step_max, code;
		span = (count > DEPTH) ? DEPTH : count;
		set_entry_count(count);
		step_max = CODE_MAX / (span + 1);
		code = $urandom_range(0, step_max);
		for (int unsigned i = 0; i < span; i++) begin
			case (fill)
				FILL_KEEP: begin
					if (!shadow_written[i])
						store_code(i, $urandom_range(0, CODE_MAX));
				end
				FILL_ASCENDING: begin
					store_code(i, code);
					code += $urandom_range(1, step_max);
				end
				FILL_REPEATS: begin
					store_code(i, code);
					code += ($urandom_range(0, 2) == 0) ? $urandom_range(1, step_max) : 0;
				end
				default: begin
					store_code(i, $urandom_range(0, CODE_MAX));
				end
			endcase
		end
		repeat (ops) random_op(span);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid <= 1'b0;
		command <= CMD_WRITE;
		entry_index <= '0;
		char_code <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 35;
		recv_idle_pct = 49;

		// Empty table: lookups return nothing; extremes of index and code
		set_entry_count(0);
		find_code(0);
		find_code(CODE_MAX);
		store_code(0, 0);
		store_code(1, 5);
		store_code(2, CODE_MAX);
		store_code(INDEX_MAX, CODE_MAX);
		store_code(INDEX_MAX, 0);

		// Three entries: each one hits, and two codes between them miss
		set_entry_count(3);
		find_code(0);
		find_code(5);
		find_code(CODE_MAX);
		find_code(3);
		find_code(CODE_MAX - 1);

		// One entry: left edge ends the search below the smallest code
		set_entry_count(1);
		store_code(0, 100);
		find_code(50);
		find_code(100);
		find_code(200);

		// Random part, small tables mostly
		run_phase(0, 30, FILL_KEEP);
		run_phase(1, 40, FILL_ASCENDING);
		run_phase(2, 40, FILL_ASCENDING);
		run_phase($urandom_range(3, 40), 60, FILL_ASCENDING);
		run_phase($urandom_range(3, 40), 60, FILL_REPEATS);

		send_idle_pct = 49;
		recv_idle_pct = 35;
		run_phase($urandom_range(3, 40), 60, FILL_SCRAMBLED);
		run_phase(DEPTH, 150, FILL_ASCENDING);
		// counts past the depth saturate
		run_phase(2047, 80, FILL_KEEP);
		run_phase(DEPTH + 1, 60, FILL_KEEP);
		run_phase($urandom_range(41, 200), 80, FILL_ASCENDING);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase($urandom_range(3, 40), 80, FILL_ASCENDING);
		run_phase($urandom_range(3, 40), 80, FILL_REPEATS);
		run_phase(7, 60, FILL_SCRAMBLED);
		run_phase(DEPTH - 1, 60, FILL_KEEP);
		run_phase($urandom_range(1, 40), 100, FILL_ASCENDING);

		wait_quiet();
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
